@@ rtl/box_center_morton_code_macros.svh @@
`ifndef BOX_CENTER_MORTON_CODE_MACROS_SVH
`define BOX_CENTER_MORTON_CODE_MACROS_SVH
// implication checked on every clock edge outside reset
`define BCM_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define BCM_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

@@ rtl/bcmc_pkg.sv @@
package bcmc_pkg;
   localparam int AxisBits  = 10;
   localparam int CoordW    = 32;
   localparam int KeyW      = 3 * AxisBits;
   localparam int SumW      = CoordW + 2;
   localparam int CsrIdxW   = 3;
   localparam int NumStages = AxisBits + 4;
   localparam logic [AxisBits-1:0] AxisMax = {AxisBits{1'b1}};
   localparam logic [AxisBits-1:0] AxisMid = AxisMax >> 1;

   typedef enum logic [CsrIdxW-1:0] {
      REG_FRAME_VALID = 3'd0,
      REG_FRAME_MIN_X = 3'd1,
      REG_FRAME_MIN_Y = 3'd2,
      REG_FRAME_MIN_Z = 3'd3,
      REG_FRAME_MAX_X = 3'd4,
      REG_FRAME_MAX_Y = 3'd5,
      REG_FRAME_MAX_Z = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      AX_DIV  = 2'd0,
      AX_ZERO = 2'd1,
      AX_FULL = 2'd2,
      AX_MID  = 2'd3
   } axis_mode_type;

   typedef struct packed {
      axis_mode_type       mode;
      logic [SumW-1:0]     num;
      logic [SumW-1:0]     den;
      logic [SumW:0]       rem;
      logic [AxisBits-1:0] quo;
   } axis_type;
endpackage

@@ rtl/box_center_morton_code.sv @@
// A request passes through the sum, mode, division, round and key stages in order to rsp valid.
// Throughput: one box per cycle; the pipeline advances whenever its output stage is free.
// Restoring division runs one quotient bit per stage, ten stages per axis in parallel.
// Reset (synchronous, active high) clears valid bits and frame registers to zero.
module box_center_morton_code
   import bcmc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [6*CoordW-1:0]  req_tdata,  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
   input  logic                 req_tuser,  // box_valid
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata,  // morton_key, zero pad
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CsrIdxW-1:0]   csr_index,
   input  logic [CoordW-1:0]    csr_wdata
);
`include "box_center_morton_code_macros.svh"

   logic                     frame_valid_ff;
   logic signed [CoordW-1:0] frame_lo_ff [3];
   logic signed [CoordW-1:0] frame_hi_ff [3];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_valid_ff <= 1'b0;
         for (int a = 0; a < 3; a++) begin
            frame_lo_ff[a] <= '0;
            frame_hi_ff[a] <= '0;
         end
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_FRAME_VALID: frame_valid_ff <= csr_wdata[0];
            REG_FRAME_MIN_X: frame_lo_ff[0] <= csr_wdata;
            REG_FRAME_MIN_Y: frame_lo_ff[1] <= csr_wdata;
            REG_FRAME_MIN_Z: frame_lo_ff[2] <= csr_wdata;
            REG_FRAME_MAX_X: frame_hi_ff[0] <= csr_wdata;
            REG_FRAME_MAX_Y: frame_hi_ff[1] <= csr_wdata;
            REG_FRAME_MAX_Z: frame_hi_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage 0: sums, stage 1: mode, stages 2..11: division, 12: round, 13: key
   logic       vld_ff [NumStages];
   logic       ok_ff  [NumStages];
   logic       adv;
   axis_type   ax_ff  [NumStages][3];
   logic signed [SumW-1:0] s_ff [3];
   logic signed [SumW-1:0] lo2_ff [3];
   logic signed [SumW-1:0] hi2_ff [3];
   logic [KeyW-1:0] key_ff;

   assign adv        = !vld_ff[NumStages-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[NumStages-1];
   assign rsp_tdata  = {{(32-KeyW){1'b0}}, key_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NumStages; s++) vld_ff[s] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_tvalid;
         for (int s = 1; s < NumStages; s++) vld_ff[s] <= vld_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      logic signed [SumW-1:0] num, den;
      logic [SumW:0] r;
      logic [KeyW-1:0] key_in;
      if (adv) begin
         ok_ff[0] <= req_tuser && frame_valid_ff;
         for (int a = 0; a < 3; a++) begin
            s_ff[a] <= SumW'($signed(req_tdata[a*CoordW +: CoordW]))
                     + SumW'($signed(req_tdata[(a+3)*CoordW +: CoordW]));
            lo2_ff[a] <= SumW'(frame_lo_ff[a]) <<< 1;
            hi2_ff[a] <= SumW'(frame_hi_ff[a]) <<< 1;
         end
         for (int s = 1; s < NumStages; s++) ok_ff[s] <= ok_ff[s-1];
         for (int a = 0; a < 3; a++) begin
            num = s_ff[a] - lo2_ff[a];
            den = hi2_ff[a] - lo2_ff[a];
            ax_ff[1][a].num <= num;
            ax_ff[1][a].den <= den;
            ax_ff[1][a].rem <= {1'b0, num};
            ax_ff[1][a].quo <= '0;
            if (!(hi2_ff[a] > lo2_ff[a]))   ax_ff[1][a].mode <= AX_MID;
            else if (num <= 0)              ax_ff[1][a].mode <= AX_ZERO;
            else if (num >= den)            ax_ff[1][a].mode <= AX_FULL;
            else                            ax_ff[1][a].mode <= AX_DIV;
            for (int s = 2; s <= AxisBits + 1; s++) begin
               axis_type t;
               t = ax_ff[s-1][a];
               r = t.rem << 1;
               if (r >= {1'b0, t.den}) begin
                  t.rem = r - {1'b0, t.den};
                  t.quo = {t.quo[AxisBits-2:0], 1'b1};
               end else begin
                  t.rem = r;
                  t.quo = {t.quo[AxisBits-2:0], 1'b0};
               end
               ax_ff[s][a] <= t;
            end
         end
         for (int a = 0; a < 3; a++) begin
            logic [SumW:0] rr;
            logic [AxisBits-1:0] q;
            axis_type t;
            t = ax_ff[AxisBits+1][a];
            q = t.quo;
            if (t.rem >= {1'b0, t.num}) begin
               rr = t.rem - {1'b0, t.num};
            end else begin
               q  = q - 1'b1;
               rr = t.rem + {1'b0, t.den} - {1'b0, t.num};
            end
            if ((rr << 1) >= {1'b0, t.den}) q = q + 1'b1;
            case (t.mode)
               AX_ZERO: q = '0;
               AX_FULL: q = AxisMax;
               AX_MID:  q = AxisMid;
               default: ;
            endcase
            t.quo = q;
            ax_ff[AxisBits+2][a] <= t;
         end
         for (int i = 0; i < AxisBits; i++)
            for (int a = 0; a < 3; a++)
               key_in[3*i+a] = ok_ff[AxisBits+2] && ax_ff[AxisBits+2][a].quo[i];
         key_ff <= key_in;
      end
   end

   `BCM_ASSERT_NXT(a_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "rsp dropped")
   `BCM_ASSERT_IMP(a_ready, rsp_tvalid && !rsp_tready, !req_tready, "accept during stall")
   `BCM_ASSERT_NXT(a_zero, adv && !ok_ff[AxisBits+2], key_ff == '0, "invalid box gave key")
endmodule

@@ verif/box_center_morton_code_checker.sv @@
module box_center_morton_code_checker
   import bcmc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [6*CoordW-1:0] req_tdata,
   input  logic                req_tuser,
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [31:0]         rsp_tdata,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CoordW-1:0]   csr_wdata,
   output int                  fail_count,
   output int                  keys_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic                     frame_ok;
   logic signed [CoordW-1:0] frame_lo [3];
   logic signed [CoordW-1:0] frame_hi [3];
   logic [31:0]              key_queue [$];

   function automatic logic [AxisBits-1:0] axis_level(logic signed [CoordW-1:0] bmin,
         logic signed [CoordW-1:0] bmax, logic signed [CoordW-1:0] lo,
         logic signed [CoordW-1:0] hi);
      longint num;
      longint den;
      longint prod;
      if (!(hi > lo)) return AxisMid;
      num = longint'(bmin) + longint'(bmax) - 2 * longint'(lo);
      den = 2 * (longint'(hi) - longint'(lo));
      if (num <= 0) return '0;
      if (num >= den) return AxisMax;
      prod = num * longint'(AxisMax);
      return AxisBits'((2 * prod + den) / (2 * den));
   endfunction

   function automatic logic [31:0] center_key(logic [6*CoordW-1:0] box, logic box_ok);
      logic [31:0]         key;
      logic [AxisBits-1:0] q;
      key = '0;
      if (box_ok && frame_ok) begin
         for (int a = 0; a < 3; a++) begin
            q = axis_level(box[a*CoordW +: CoordW], box[(a+3)*CoordW +: CoordW],
                           frame_lo[a], frame_hi[a]);
            for (int i = 0; i < AxisBits; i++) key[3*i+a] = q[i];
         end
      end
      return key;
   endfunction

   assign keys_pending = key_queue.size();

   always @(posedge clock) begin
      if (reset) begin
         frame_ok <= 1'b0;
         for (int a = 0; a < 3; a++) begin
            frame_lo[a] <= '0;
            frame_hi[a] <= '0;
         end
         fail_count <= 0;
         key_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_FRAME_VALID: frame_ok <= csr_wdata[0];
               REG_FRAME_MIN_X: frame_lo[0] <= csr_wdata;
               REG_FRAME_MIN_Y: frame_lo[1] <= csr_wdata;
               REG_FRAME_MIN_Z: frame_lo[2] <= csr_wdata;
               REG_FRAME_MAX_X: frame_hi[0] <= csr_wdata;
               REG_FRAME_MAX_Y: frame_hi[1] <= csr_wdata;
               REG_FRAME_MAX_Z: frame_hi[2] <= csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            key_queue.insert(key_queue.size(), center_key(req_tdata, req_tuser));
         if (rsp_tvalid && rsp_tready) begin
            if (key_queue.size() == 0) begin
               $display("%0t: unexpected key, expected none, actual %h", $realtime, rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               if (rsp_tdata !== key_queue[0]) begin
                  $display("%0t: morton_key mismatch, expected %h, actual %h",
                           $realtime, key_queue[0], rsp_tdata);
                  fail_count <= fail_count + 1;
               end
               void'(key_queue.pop_front());
            end
         end
      end
   end
endmodule

@@ verif/box_center_morton_code_test.sv @@
module box_center_morton_code_test;
   import bcmc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RandomBoxes = 950;
   localparam int CycleLimit  = 200000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [6*CoordW-1:0] req_tdata = '0;
   logic                req_tuser = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [31:0]         rsp_tdata;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CsrIdxW-1:0]  csr_index = '0;
   logic [CoordW-1:0]   csr_wdata = '0;
   int                  fail_count;
   int                  keys_pending;
   int                  cycle_count = 0;
   bit                  calm = 1'b0;
   bit                  hold_off = 1'b0;
   logic signed [CoordW-1:0] span_lo;
   logic signed [CoordW-1:0] span_hi;

   box_center_morton_code uut (.*);
   box_center_morton_code_checker checker_inst (.*);

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            n = $urandom_range(1, 8);
            repeat (n) @(negedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic write_reg(csr_index_type idx, logic [CoordW-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain_keys();
      while (keys_pending != 0) @(posedge clock);
      repeat (NumStages + 6) @(posedge clock);
   endtask

   task automatic load_frame(logic ok, logic [CoordW-1:0] lo [3], logic [CoordW-1:0] hi [3]);
      drain_keys();
      write_reg(REG_FRAME_VALID, {31'b0, ok});
      write_reg(REG_FRAME_MIN_X, lo[0]);
      write_reg(REG_FRAME_MIN_Y, lo[1]);
      write_reg(REG_FRAME_MIN_Z, lo[2]);
      write_reg(REG_FRAME_MAX_X, hi[0]);
      write_reg(REG_FRAME_MAX_Y, hi[1]);
      write_reg(REG_FRAME_MAX_Z, hi[2]);
   endtask

   task automatic send_box(logic ok, logic [6*CoordW-1:0] box);
      int n;
      if (!calm && $urandom_range(0, 6) == 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         n = $urandom_range(1, 8);
         repeat (n - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= ok;
      req_tdata  <= box;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   function automatic logic [CoordW-1:0] coord_near(logic signed [CoordW-1:0] lo,
         logic signed [CoordW-1:0] hi);
      longint w;
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return {1'b1, {(CoordW-1){1'b0}}};
         2: return {1'b0, {(CoordW-1){1'b1}}};
         default: begin
            w = longint'(hi) - longint'(lo);
            if (w < 2) w = 2;
            return CoordW'(longint'(lo) - w / 8 + longint'({$urandom, $urandom} % (w + w / 4)));
         end
      endcase
   endfunction

   task automatic random_phase(logic ok, logic [CoordW-1:0] lo [3], logic [CoordW-1:0] hi [3],
         int count);
      logic [6*CoordW-1:0] box;
      load_frame(ok, lo, hi);
      for (int k = 0; k < count; k++) begin
         for (int f = 0; f < 6; f++) box[f*CoordW +: CoordW] = coord_near(lo[f%3], hi[f%3]);
         send_box($urandom_range(0, 15) != 0, box);
      end
      send_idle();
   endtask

   initial begin
      logic [CoordW-1:0] lo [3];
      logic [CoordW-1:0] hi [3];
      logic [6*CoordW-1:0] box;
      int per_phase;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: frame 0..16.0 on x, -8..8 on y, z empty
      lo = '{32'h0, 32'hFFF8_0000, 32'h0001_0000};
      hi = '{32'h0010_0000, 32'h0008_0000, 32'h0001_0000};
      load_frame(1'b1, lo, hi);
      send_box(1'b1, '0);
      send_box(1'b0, {6{32'h0004_0000}});
      send_box(1'b1, {32'h0, 32'h0008_0000, 32'h0010_0000,
                      32'h0, 32'h0008_0000, 32'h0010_0000}); // upper faces
      send_box(1'b1, {6{32'h8000_0000}});
      send_box(1'b1, {6{32'h7FFF_FFFF}});
      send_box(1'b1, {32'h0, 32'h0, 32'h0008_0000, 32'h0, 32'h0, 32'h0008_0000});
      send_box(1'b1, {32'h0, 32'h0, 32'h0000_0080, 32'h0, 32'h0, 32'h0});
      send_box(1'b1, {32'h0, 32'h0, 32'h0000_0040, 32'h0, 32'h0, 32'h0});
      send_box(1'b1, {32'h0, 32'h0, 32'h0000_0001, 32'h0, 32'h0, 32'h0010_0000});
      send_box(1'b1, {32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0010_0000}); // inverted box
      send_box(1'b1, {32'h1, 32'h2, 32'h0000_FFFF, 32'h3, 32'h4, 32'h000F_FFFF});
      send_idle();
      load_frame(1'b0, lo, hi);
      send_box(1'b1, {6{32'h0004_0000}});
      send_idle();
      // full-range frame, then inverted frame
      lo = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
      hi = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
      load_frame(1'b1, lo, hi);
      send_box(1'b1, {6{32'h7FFF_FFFF}});
      send_box(1'b1, {6{32'h8000_0000}});
      send_box(1'b1, {6{32'h0}});
      send_box(1'b1, {32'hFFFF_FFFF, 32'h0, 32'h1, 32'h0, 32'h0, 32'h0});
      send_idle();
      load_frame(1'b1, hi, lo);
      send_box(1'b1, {6{32'h1234_5678}});
      send_idle();

      // fill the pipeline while the receiver holds off
      fork
         begin
            hold_off = 1'b1;
            repeat (60) @(posedge clock);
            hold_off = 1'b0;
         end
      join_none
      for (int k = 0; k < 40; k++) begin
         box = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
         send_box(1'b1, box);
      end
      send_idle();
      wait fork;

      per_phase = RandomBoxes / 6;
      for (int p = 0; p < 6; p++) begin
         if (p == 5) calm = 1'b1;
         for (int a = 0; a < 3; a++) begin
            span_lo = $urandom;
            span_hi = $urandom;
            if (p == 0) begin
               span_lo = $urandom_range(0, 65535);
               span_hi = span_lo + $urandom_range(1, 4000);
            end else if (p != 4 && span_hi < span_lo) begin
               {span_lo, span_hi} = {span_hi, span_lo};
            end
            if (span_hi == span_lo) span_hi = span_lo + 1;
            lo[a] = span_lo;
            hi[a] = span_hi;
         end
         random_phase(p != 3 || $urandom_range(0, 1) == 1, lo, hi, per_phase);
      end

      while (keys_pending != 0) @(posedge clock);
      repeat (NumStages + 6) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
